>>> design/lqsi_pkg.sv
package lqsi_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 31;

  // command codes
  localparam logic [2:0] KindPush   = 3'd0;
  localparam logic [2:0] KindPop    = 3'd1;
  localparam logic [2:0] KindInsert = 3'd2;
  localparam logic [2:0] KindErase  = 3'd3;
  localparam logic [2:0] KindGet    = 3'd4;
  localparam logic [2:0] KindClear  = 3'd5;

  localparam logic [CntW-1:0] CapCount = CntW'(Capacity);

endpackage

>>> design/list_queue_sorted_insert.sv
// Push, clear, unknown kinds and rejects end in the decode state; get adds a memory read;
//   pop, insert and erase walk the entries; insert scans to the first entry <= the value,
//   moves the entries from there on up by one and writes the value, erase compacts the rest.
// Throughput: one command at a time; busy from the cycle after start up to the strobe.
//   The entry memory sets the pace: each scanned or moved entry takes a read and a write or compare state.
// Reset (rst_ni low, async): store empty, sequencer idle. The receiver cannot stall.
module list_queue_sorted_insert (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 kind_i,
  input  logic signed [31:0]         value_i,
  input  logic [7:0]                 position_i,
  output logic                       done_o,
  output logic                       ok_o,
  output logic [lqsi_pkg::ValW-1:0]  read_value_o,
  output logic [lqsi_pkg::CntW-1:0]  count_o
);
  import lqsi_pkg::*;

  // sequencer states
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDisp = 4'd1;  // decode latched command
  localparam logic [3:0] StGetE = 4'd2;  // get data returned
  localparam logic [3:0] StPop0 = 4'd3;  // head returned
  localparam logic [3:0] StShR  = 4'd4;  // pop: read entry idx
  localparam logic [3:0] StShW  = 4'd5;  // pop: write it at idx-1
  localparam logic [3:0] StInR  = 4'd6;  // insert scan: read idx
  localparam logic [3:0] StInE  = 4'd7;  // insert scan: compare
  localparam logic [3:0] StOpR  = 4'd8;  // open slot: read idx-1
  localparam logic [3:0] StOpW  = 4'd9;  // open slot: write at idx
  localparam logic [3:0] StErR  = 4'd10; // erase: read idx
  localparam logic [3:0] StErE  = 4'd11; // erase: compare and compact

  logic [3:0]      state_q, state_d;
  logic [2:0]      kind_q;
  logic [ValW-1:0] mag_q;
  logic            neg_q;
  logic [7:0]      pos_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;     // scan / move index
  logic [CntW-1:0] at_q, at_d;       // insert slot
  logic [CntW-1:0] wr_q, wr_d;       // erase write pointer
  logic            found_q, found_d;
  logic            done_q, done_d;
  logic            ok_q, ok_d;
  logic [ValW-1:0] rv_q, rv_d;

  // entry memory: one write and one registered read per cycle
  logic [ValW-1:0] mem_q [Capacity];
  logic [ValW-1:0] rdata_q;
  logic [AddrW-1:0] raddr, waddr;
  logic [ValW-1:0]  wdata;
  logic             we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    at_d    = at_q;
    wr_d    = wr_q;
    found_d = found_q;
    done_d  = 1'b0;
    ok_d    = ok_q;
    rv_d    = rv_q;
    raddr   = idx_q[AddrW-1:0];
    waddr   = idx_q[AddrW-1:0];
    wdata   = rdata_q;
    we      = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StDisp;
        end
      end
      StDisp: begin
        case (kind_q)
          KindPush: begin
            done_d  = 1'b1;
            rv_d    = '0;
            state_d = StIdle;
            if (!neg_q && count_q < CapCount) begin
              we      = 1'b1;
              waddr   = count_q[AddrW-1:0];
              wdata   = mag_q;
              count_d = count_q + 1'b1;
              ok_d    = 1'b1;
            end else begin
              ok_d = 1'b0;
            end
          end
          KindPop: begin
            if (count_q == '0) begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              rv_d    = '0;
              state_d = StIdle;
            end else begin
              raddr   = '0;
              state_d = StPop0;
            end
          end
          KindInsert: begin
            if (neg_q || count_q >= CapCount) begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              rv_d    = '0;
              state_d = StIdle;
            end else begin
              idx_d   = '0;
              state_d = StInR;
            end
          end
          KindErase: begin
            if (neg_q) begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              rv_d    = '0;
              state_d = StIdle;
            end else begin
              idx_d   = '0;
              wr_d    = '0;
              found_d = 1'b0;
              state_d = StErR;
            end
          end
          KindGet: begin
            if (pos_q < {1'b0, count_q}) begin
              raddr   = pos_q[AddrW-1:0];
              state_d = StGetE;
            end else begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              rv_d    = '0;
              state_d = StIdle;
            end
          end
          KindClear: begin
            count_d = '0;
            done_d  = 1'b1;
            ok_d    = 1'b1;
            rv_d    = '0;
            state_d = StIdle;
          end
          default: begin
            done_d  = 1'b1;
            ok_d    = 1'b0;
            rv_d    = '0;
            state_d = StIdle;
          end
        endcase
      end
      StGetE: begin
        done_d  = 1'b1;
        ok_d    = 1'b1;
        rv_d    = rdata_q;
        state_d = StIdle;
      end
      StPop0: begin
        rv_d    = rdata_q;       // held until the strobe
        idx_d   = CntW'(1);
        state_d = StShR;
      end
      StShR: begin
        if (idx_q < count_q) begin
          state_d = StShW;
        end else begin
          count_d = count_q - 1'b1;
          done_d  = 1'b1;
          ok_d    = 1'b1;
          state_d = StIdle;
        end
      end
      StShW: begin
        we      = 1'b1;
        waddr   = idx_q[AddrW-1:0] - 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = StShR;
      end
      StInR: begin
        if (idx_q < count_q) begin
          state_d = StInE;
        end else begin
          // no smaller or equal entry: append at the tail
          at_d    = count_q;
          idx_d   = count_q;
          state_d = StOpR;
        end
      end
      StInE: begin
        if (rdata_q <= mag_q) begin
          at_d    = idx_q;
          idx_d   = count_q;
          state_d = StOpR;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StInR;
        end
      end
      StOpR: begin
        if (idx_q > at_q) begin
          raddr   = idx_q[AddrW-1:0] - 1'b1;
          state_d = StOpW;
        end else begin
          we      = 1'b1;
          waddr   = at_q[AddrW-1:0];
          wdata   = mag_q;
          count_d = count_q + 1'b1;
          done_d  = 1'b1;
          ok_d    = 1'b1;
          rv_d    = '0;
          state_d = StIdle;
        end
      end
      StOpW: begin
        we      = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = StOpR;
      end
      StErR: begin
        if (idx_q < count_q) begin
          state_d = StErE;
        end else begin
          count_d = wr_q;
          done_d  = 1'b1;
          ok_d    = found_q;
          rv_d    = '0;
          state_d = StIdle;
        end
      end
      StErE: begin
        if (rdata_q == mag_q) begin
          found_d = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = wr_q[AddrW-1:0];
          wr_d  = wr_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = StErR;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload and loop registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      kind_q <= kind_i;
      neg_q  <= value_i[31];
      mag_q  <= value_i[ValW-1:0];
      pos_q  <= position_i;
    end
    idx_q   <= idx_d;
    at_q    <= at_d;
    wr_q    <= wr_d;
    found_q <= found_d;
    ok_q    <= ok_d;
    rv_q    <= rv_d;
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign read_value_o = rv_q;
  assign count_o      = count_q;

endmodule

>>> design/lqsi_checker.sv
module lqsi_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic                      ok_o,
  input logic [lqsi_pkg::ValW-1:0] read_value_o,
  input logic [lqsi_pkg::CntW-1:0] count_o
);
  import lqsi_pkg::*;

  // result strobe only comes as the sequencer goes idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");

  // a start transfer always leads into a busy command
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");

  // failed commands return no data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (read_value_o == '0)) else $error("data on failure");

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= CapCount) else $error("count over capacity");

  // count changes only when a command completes
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(count_o)) else $error("count moved without result");

endmodule

bind list_queue_sorted_insert lqsi_checker u_lqsi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .ok_o         (ok_o),
  .read_value_o (read_value_o),
  .count_o      (count_o)
);
